### rtl/arpc_pkg.sv
// arpc_pkg: types, codes and sizes shared by the ARP cache responder modules.
// No dependencies.
package arpc_pkg;

  localparam int CacheEntries = 64;
  localparam int IdxW = $clog2(CacheEntries);

  localparam logic [1:0] ReqArp  = 2'd0;
  localparam logic [1:0] ReqLook = 2'd1;
  localparam logic [1:0] ReqTick = 2'd2;
  localparam logic [1:0] ReqRsvd = 2'd3;

  localparam logic [15:0] OpRequest = 16'd1;
  localparam logic [15:0] OpReply   = 16'd2;
  localparam logic [15:0] OpRarpReq = 16'd3;
  localparam logic [15:0] OpRarpRep = 16'd4;

  localparam logic [3:0] StDropped = 4'd0;
  localparam logic [3:0] StReply   = 4'd1;
  localparam logic [3:0] StHit     = 4'd2;
  localparam logic [3:0] StMiss    = 4'd3;
  localparam logic [3:0] StBadMac  = 4'd4;
  localparam logic [3:0] StBadIp   = 4'd5;
  localparam logic [3:0] StRarp    = 4'd6;
  localparam logic [3:0] StBadOp   = 4'd7;
  localparam logic [3:0] StTick    = 4'd8;

  localparam logic [1:0] CfgLocalIp  = 2'd0;
  localparam logic [1:0] CfgLocalMac = 2'd1;
  localparam logic [1:0] CfgProxy    = 2'd2;
  localparam logic [1:0] CfgTimeout  = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_DRAIN, S_WRITE, S_DONE
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;       // capture item, reset scan
    logic scan;       // advance scan (one entry read per cycle)
    logic write;      // write-back refresh/insert
    logic finish;     // build result
    logic tick;       // advance time
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_last;  // last address issued
  } stat_t;

endpackage

### rtl/arpc_ctrl.sv
// arpc_ctrl: sequencer for the ARP cache responder.
// Depends on arpc_pkg.
module arpc_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [1:0]      req_type,
  output logic            out_valid,
  input  logic            out_ready,
  input  arpc_pkg::stat_t stat,
  output arpc_pkg::cmd_t  cmd
);

  arpc_pkg::state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= arpc_pkg::S_IDLE;
    else     state <= state_next;
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    case (state)
      arpc_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (req_type == arpc_pkg::ReqArp || req_type == arpc_pkg::ReqLook)
            state_next = arpc_pkg::S_SCAN;
          else begin
            if (req_type == arpc_pkg::ReqTick) cmd.tick = 1'b1;
            state_next = arpc_pkg::S_DRAIN;
          end
        end
      end
      arpc_pkg::S_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.scan_last) state_next = arpc_pkg::S_DRAIN;
      end
      arpc_pkg::S_DRAIN: begin
        // last read data and its compare settle
        cmd.scan = 1'b1;
        state_next = arpc_pkg::S_WRITE;
      end
      arpc_pkg::S_WRITE: begin
        cmd.write = 1'b1;
        cmd.finish = 1'b1;
        state_next = arpc_pkg::S_DONE;
      end
      arpc_pkg::S_DONE: begin
        out_valid = 1'b1;
        if (out_ready) state_next = arpc_pkg::S_IDLE;
      end
      default: state_next = arpc_pkg::S_IDLE;
    endcase
  end

endmodule

### rtl/arpc_datapath.sv
// arpc_datapath: cache memories, scan compare logic, time counter, result regs.
// Depends on arpc_pkg.
module arpc_datapath (
  input  logic            clk,
  input  logic            rst,
  input  arpc_pkg::cmd_t  cmd,
  output arpc_pkg::stat_t stat,
  input  logic            cfg_valid,
  input  logic [1:0]      cfg_index,
  input  logic [63:0]     cfg_data,
  input  logic [1:0]      req_type,
  input  logic [15:0]     opcode,
  input  logic [47:0]     sender_mac,
  input  logic [31:0]     sender_ip,
  input  logic [31:0]     target_ip,
  input  logic [3:0]      in_port,
  input  logic            route_found,
  input  logic [3:0]      route_port,
  input  logic [47:0]     query_mac,
  output logic [3:0]      status,
  output logic [3:0]      out_port,
  output logic [47:0]     reply_dest_mac,
  output logic [31:0]     reply_dest_ip,
  output logic [31:0]     reply_src_ip,
  output logic [47:0]     reply_src_mac,
  output logic [31:0]     found_ip,
  output logic            insert_dropped
);

  localparam int N = arpc_pkg::CacheEntries;
  localparam int IW = arpc_pkg::IdxW;

  // configuration registers
  logic [31:0] local_ip, cache_timeout;
  logic [47:0] local_mac;
  logic        proxy_en;
  always_ff @(posedge clk) begin
    if (rst) begin
      local_ip <= '0; local_mac <= '0; proxy_en <= 1'b0; cache_timeout <= 32'd120;
    end else if (cfg_valid) begin
      case (cfg_index)
        arpc_pkg::CfgLocalIp:  local_ip <= cfg_data[31:0];
        arpc_pkg::CfgLocalMac: local_mac <= cfg_data[47:0];
        arpc_pkg::CfgProxy:    proxy_en <= cfg_data[0];
        arpc_pkg::CfgTimeout:  cache_timeout <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  // captured item
  logic [1:0]  r_req;
  logic [15:0] r_op;
  logic [47:0] r_smac, r_qmac;
  logic [31:0] r_sip, r_tip;
  logic [3:0]  r_port;
  logic        r_recog;
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      r_req <= req_type; r_op <= opcode; r_smac <= sender_mac; r_qmac <= query_mac;
      r_sip <= sender_ip; r_tip <= target_ip; r_port <= in_port;
      r_recog <= (target_ip == local_ip) ||
                 (proxy_en && route_found && (route_port != in_port));
    end
  end

  // time counter, saturating
  logic [31:0] time_now;
  always_ff @(posedge clk) begin
    if (rst) time_now <= '0;
    else if (cmd.tick && time_now != 32'hFFFF_FFFF) time_now <= time_now + 32'd1;
  end

  // valid bits in flops
  logic [N-1:0] valid;

  // cache memories (one write, one registered read per cycle)
  logic [31:0] mem_ip [N];
  logic [47:0] mem_mac [N];
  logic [31:0] mem_stamp [N];
  logic [31:0] rd_ip, rd_stamp;
  logic [47:0] rd_mac;
  logic        rd_vld, rd_live;
  logic [IW-1:0] rd_idx;

  logic [IW:0] addr;   // scan read address, widened for end detection
  logic        wr_en;
  logic [IW-1:0] wr_idx;

  assign stat.scan_last = (addr == (IW+1)'(N - 1));

  always_ff @(posedge clk) begin
    rd_ip <= mem_ip[addr[IW-1:0]];
    rd_mac <= mem_mac[addr[IW-1:0]];
    rd_stamp <= mem_stamp[addr[IW-1:0]];
    if (wr_en) begin
      mem_ip[wr_idx] <= r_sip;
      mem_mac[wr_idx] <= r_smac;
      mem_stamp[wr_idx] <= time_now;
    end
  end

  // scan bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      addr <= '0; rd_live <= 1'b0;
    end else if (cmd.load) begin
      addr <= '0; rd_live <= 1'b0;
    end else if (cmd.scan) begin
      addr <= addr + 1'b1;
      rd_live <= (addr < (IW+1)'(N));
      rd_idx <= addr[IW-1:0];
      rd_vld <= valid[addr[IW-1:0]];
    end else rd_live <= 1'b0;
  end

  // scan results
  logic        m_hit, f_hit, l_hit;
  logic [IW-1:0] m_idx, f_idx;
  logic [31:0] l_best;
  logic [32:0] age_sum;
  assign age_sum = {1'b0, rd_stamp} + {1'b0, cache_timeout};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      m_hit <= 1'b0; f_hit <= 1'b0; l_hit <= 1'b0; l_best <= '0;
    end else if (rd_live) begin
      if (rd_vld && rd_ip == r_sip && !m_hit) begin
        m_hit <= 1'b1; m_idx <= rd_idx;
      end
      if (!rd_vld && !f_hit) begin
        f_hit <= 1'b1; f_idx <= rd_idx;
      end
      if (rd_vld && rd_mac == r_qmac && r_qmac != '0 &&
          age_sum >= {1'b0, time_now} && (!l_hit || rd_ip < l_best)) begin
        l_hit <= 1'b1; l_best <= rd_ip;
      end
    end
  end

  // write-back decision
  logic is_arp, bad;
  assign is_arp = (r_req == arpc_pkg::ReqArp);
  assign bad = (r_smac == '0) || (r_sip == '0);
  always_comb begin
    wr_en = 1'b0;
    wr_idx = m_idx;
    if (cmd.write && is_arp && !bad) begin
      if (m_hit) wr_en = 1'b1;
      else if (r_recog && f_hit) begin
        wr_en = 1'b1; wr_idx = f_idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) valid <= '0;
    else if (wr_en) valid[wr_idx] <= 1'b1;
  end

  // result registers
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      status <= arpc_pkg::StDropped;
      out_port <= '0; reply_dest_mac <= '0; reply_dest_ip <= '0;
      reply_src_ip <= '0; reply_src_mac <= '0; found_ip <= '0;
      insert_dropped <= 1'b0;
      if (is_arp) begin
        if (r_smac == '0) status <= arpc_pkg::StBadMac;
        else if (r_sip == '0) status <= arpc_pkg::StBadIp;
        else if (r_recog) begin
          insert_dropped <= !m_hit && !f_hit;
          if (r_op == arpc_pkg::OpRequest) begin
            status <= arpc_pkg::StReply;
            out_port <= r_port; reply_dest_mac <= r_smac; reply_dest_ip <= r_sip;
            reply_src_ip <= r_tip; reply_src_mac <= local_mac;
          end else if (r_op == arpc_pkg::OpReply) status <= arpc_pkg::StDropped;
          else if (r_op == arpc_pkg::OpRarpReq || r_op == arpc_pkg::OpRarpRep)
            status <= arpc_pkg::StRarp;
          else status <= arpc_pkg::StBadOp;
        end
      end else if (r_req == arpc_pkg::ReqLook) begin
        if (l_hit) begin
          status <= arpc_pkg::StHit; found_ip <= l_best;
        end else status <= arpc_pkg::StMiss;
      end else if (r_req == arpc_pkg::ReqTick) begin
        status <= arpc_pkg::StTick;
      end
    end
  end

endmodule

### rtl/arp_cache_responder.sv
// arp_cache_responder: top level of the ARP receive path with IP-to-MAC cache.
// Depends on arpc_pkg, arpc_ctrl, arpc_datapath.
//
// One item at a time. A packet or reverse lookup scans all 64 cache entries,
// one memory read per cycle, then writes back and presents its result: after
// the reads, a drain state for the last compare and a write-back state come
// before result valid; the next item is taken the cycle after the result beat.
// Ticks and unknown request types skip the scan. No reset-time clearing pass:
// valid bits are flops cleared by reset. Config writes are always accepted.
module arp_cache_responder (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  req_type,
  input  logic [15:0] opcode,
  input  logic [47:0] sender_mac,
  input  logic [31:0] sender_ip,
  input  logic [31:0] target_ip,
  input  logic [3:0]  in_port,
  input  logic        route_found,
  input  logic [3:0]  route_port,
  input  logic [47:0] query_mac,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  status,
  output logic [3:0]  out_port,
  output logic [47:0] reply_dest_mac,
  output logic [31:0] reply_dest_ip,
  output logic [31:0] reply_src_ip,
  output logic [47:0] reply_src_mac,
  output logic [31:0] found_ip,
  output logic        insert_dropped
);

  arpc_pkg::cmd_t  cmd;
  arpc_pkg::stat_t stat;

  assign cfg_ready = 1'b1;

  arpc_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .req_type, .out_valid, .out_ready,
    .stat, .cmd
  );

  arpc_datapath u_dp (
    .clk, .rst, .cmd, .stat, .cfg_valid, .cfg_index, .cfg_data,
    .req_type, .opcode, .sender_mac, .sender_ip, .target_ip, .in_port,
    .route_found, .route_port, .query_mac, .status, .out_port,
    .reply_dest_mac, .reply_dest_ip, .reply_src_ip, .reply_src_mac,
    .found_ip, .insert_dropped
  );

endmodule
